// ===== sv/ihb_pkg.sv =====
// ----------------------------------------------------------------------------
// ihb_pkg
// Constants and register indexes for the IPv4 transmit header builder.
// ----------------------------------------------------------------------------
package ihb_pkg;

	localparam int unsigned ADDR_W   = 32;
	localparam int unsigned HALF_W   = 16;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned WNUM_W   = 3;
	localparam int unsigned CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOCAL_ADDRESS   = 2'd0,
		REG_SUBNET_MASK     = 2'd1,
		REG_GATEWAY_ADDRESS = 2'd2,
		REG_UNUSED          = 2'd3
	} cfg_reg_t;

	typedef enum logic [WNUM_W-1:0] {
		WORD_LEN   = 3'd0,
		WORD_ID    = 3'd1,
		WORD_CSUM  = 3'd2,
		WORD_SRC   = 3'd3,
		WORD_DST   = 3'd4
	} word_num_t;

	localparam logic [7:0]        VER_IHL    = 8'h45;
	localparam logic [7:0]        TOS        = 8'h00;
	localparam logic [HALF_W-1:0] IDENT      = 16'h0001;
	localparam logic [HALF_W-1:0] FLAGS_FRAG = 16'h4000;
	localparam logic [7:0]        TTL        = 8'h40;
	localparam logic [HALF_W-1:0] HDR_BYTES  = 16'd20;

	// Sum of the halfwords that never change: 0x4500 + 0x0001 + 0x4000 + 0x4000
	localparam logic [HALF_W:0]   FIXED_SUM  = {1'b0, VER_IHL, TOS} + {1'b0, IDENT}
		+ {1'b0, FLAGS_FRAG} + {1'b0, TTL, 8'h00};

	typedef struct packed {
		logic [ADDR_W-1:0] dest;
		logic [7:0]        proto;
		logic [HALF_W-1:0] totlen;
		logic              wrapped;
		logic [ADDR_W-1:0] hop;
	} hdr_ctx_t;

endpackage

// ===== sv/ipv4_tx_header_builder.sv =====
// ----------------------------------------------------------------------------
// ipv4_tx_header_builder
// Builds the 20-byte IPv4 header for one send request and sends it as five
// 32-bit words, with the next hop and a length wrap flag on every word.
// ----------------------------------------------------------------------------
// A request enters a three-stage pipeline (length and partial sums with the
// subnet test, full sum and first fold, final fold and complement) and then
// an output register that sends words 0 to 4 on successive accepted cycles.
// A request passes through stages 1, 2 and 3 and then into the output register
// before its first word is valid. The output channel moves one word per cycle
// while out_ready is high; the next request is accepted and processed while
// the current header is still being sent. Configuration writes take effect
// at once and are meant to happen only while the block is idle; a write to
// the unused register index is ignored.
module ipv4_tx_header_builder
	import ihb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,

	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [ADDR_W-1:0]    dest_address,
	input  logic [7:0]           protocol_number,
	input  logic [HALF_W-1:0]    payload_length,

	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [WORD_W-1:0]    header_word,
	output logic [WNUM_W-1:0]    word_number,
	output logic                 last_word,
	output logic [ADDR_W-1:0]    next_hop,
	output logic                 length_wrapped
);

	logic [ADDR_W-1:0] local_address_q;
	logic [ADDR_W-1:0] subnet_mask_q;
	logic [ADDR_W-1:0] gateway_address_q;

	logic              v_s1, v_s2, v_s3;
	hdr_ctx_t          ctx_s1, ctx_s2, ctx_s3;
	logic [HALF_W+1:0] suma_s1;
	logic [HALF_W+1:0] sumb_s1;
	logic [HALF_W:0]   fold_s2;
	logic [HALF_W-1:0] csum_s3;

	logic              ov_q;
	hdr_ctx_t          ctx_q;
	logic [HALF_W-1:0] csum_q;
	logic [WNUM_W-1:0] cnt_q;

	logic              r1, r2, r3;
	logic              adv2, adv3;
	logic              last_q;
	logic              out_take;

	logic [HALF_W:0]   full_len;
	logic [HALF_W+2:0] sum_total;
	logic [HALF_W-1:0] fold_final;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_address_q   <= '0;
			subnet_mask_q     <= '0;
			gateway_address_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LOCAL_ADDRESS:   local_address_q   <= cfg_data;
				REG_SUBNET_MASK:     subnet_mask_q     <= cfg_data;
				REG_GATEWAY_ADDRESS: gateway_address_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign last_q   = (cnt_q == WORD_DST);
	assign out_take = ov_q && out_ready;
	assign adv3     = v_s3 && (!ov_q || (out_ready && last_q));
	assign r3       = !v_s3 || adv3;
	assign adv2     = v_s2 && r3;
	assign r2       = !v_s2 || r3;
	assign r1       = !v_s1 || r2;
	assign in_ready = r1;

	assign full_len   = {1'b0, payload_length} + {1'b0, HDR_BYTES};
	assign sum_total  = {1'b0, suma_s1} + {1'b0, sumb_s1};
	assign fold_final = fold_s2[HALF_W-1:0] + {{(HALF_W-1){1'b0}}, fold_s2[HALF_W]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			ov_q <= 1'b0;
			cnt_q <= WORD_LEN;
		end else begin
			if (r1)
				v_s1 <= in_valid;
			if (r2)
				v_s2 <= v_s1;
			if (r3)
				v_s3 <= v_s2;
			if (adv3) begin
				ov_q  <= 1'b1;
				cnt_q <= WORD_LEN;
			end else if (out_take) begin
				if (last_q) begin
					ov_q  <= 1'b0;
					cnt_q <= WORD_LEN;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (r1 && in_valid) begin
			ctx_s1.dest    <= dest_address;
			ctx_s1.proto   <= protocol_number;
			ctx_s1.totlen  <= full_len[HALF_W-1:0];
			ctx_s1.wrapped <= full_len[HALF_W];
			ctx_s1.hop     <= ((dest_address & subnet_mask_q) !=
				(local_address_q & subnet_mask_q)) ? gateway_address_q : dest_address;
			suma_s1 <= {1'b0, FIXED_SUM} + {2'b00, 8'h00, protocol_number}
				+ {2'b00, full_len[HALF_W-1:0]};
			sumb_s1 <= {2'b00, local_address_q[31:16]} + {2'b00, local_address_q[15:0]}
				+ {2'b00, dest_address[31:16]} + {2'b00, dest_address[15:0]};
		end
		if (r2 && v_s1) begin
			ctx_s2  <= ctx_s1;
			fold_s2 <= {1'b0, sum_total[HALF_W-1:0]} + {14'd0, sum_total[HALF_W+2:HALF_W]};
		end
		if (adv2) begin
			ctx_s3  <= ctx_s2;
			csum_s3 <= ~fold_final;
		end
		if (adv3) begin
			ctx_q  <= ctx_s3;
			csum_q <= csum_s3;
		end
	end

	always_comb begin
		unique case (word_num_t'(cnt_q))
			WORD_LEN:  header_word = {VER_IHL, TOS, ctx_q.totlen};
			WORD_ID:   header_word = {IDENT, FLAGS_FRAG};
			WORD_CSUM: header_word = {TTL, ctx_q.proto, csum_q};
			WORD_SRC:  header_word = local_address_q;
			WORD_DST:  header_word = ctx_q.dest;
			default:   header_word = '0;
		endcase
	end

	assign out_valid      = ov_q;
	assign word_number    = cnt_q;
	assign last_word      = last_q;
	assign next_hop       = ctx_q.hop;
	assign length_wrapped = ctx_q.wrapped;

endmodule
